>>> src/lpht_pkg.sv
package lpht_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int KEY_BITS = 16;
  localparam int SLOT_BITS = $clog2(NUM_SLOTS);
  localparam int COUNT_BITS = 5;
  localparam int DIV_BITS = 5;
  localparam int DIGIT_W = 4;
  localparam int DIV_STEPS = KEY_BITS / DIGIT_W;
  localparam int STEP_BITS = $clog2(DIV_STEPS);
  localparam logic [DIV_BITS-1:0] DIVISOR_RESET = 5'd13;

  localparam logic [2:0] FIN_INSERT = 3'd0;
  localparam logic [2:0] FIN_FULL = 3'd1;
  localparam logic [2:0] FIN_HIT = 3'd2;
  localparam logic [2:0] FIN_MISS_EMPTY = 3'd3;
  localparam logic [2:0] FIN_MISS_SCAN = 3'd4;

  typedef struct packed {
    logic                req_type;
    logic [KEY_BITS-1:0] key;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [COUNT_BITS-1:0] probe_count;
    logic [SLOT_BITS-1:0]  slot_index;
    logic                  table_full;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       probe_init;
    logic       probe_next;
    logic       write;
    logic       finish;
    logic [2:0] fin_kind;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic is_search;
    logic used;
    logic match;
    logic last;
  } status_t;

endpackage

>>> src/linear_probe_hash_table_top.sv
// Open-addressing hash table with linear probing over 16 slots of 16-bit keys.
// A request (insert or search) is taken on a clock edge where start is high
// and busy is low; busy then stays high until the request is finished.
// The home slot is the low four bits of the key modulo the configured divisor
// (slot 0 for a divisor of zero), computed four key bits per cycle from the
// top of the key down; the probe pointer is then loaded and the slots are
// examined one table read per cycle. The reported probe_count equals the
// number of slots read, except for a search that misses after reading every
// slot, which reports 17. A new request may be started in the cycle the
// strobe is high.
// The result is shown on result for exactly one cycle with done high; the
// receiver cannot stall it and must take it then.
// The divisor register is written over cfg_valid/cfg_ready/cfg_data, and
// cfg_ready is high only while the block is idle.
// Synchronous reset empties every slot, sets the divisor to 13 and aborts
// any request in flight without producing a result.
module linear_probe_hash_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lpht_pkg::req_t                req,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpht_pkg::DIV_BITS-1:0] cfg_data,
  output logic                          done,
  output lpht_pkg::rsp_t                result
);
  import lpht_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = !busy;

  lpht_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  lpht_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result)
  );

endmodule

>>> src/lpht_datapath.sv
module lpht_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpht_pkg::cmd_t                       cmd,
  input  lpht_pkg::req_t                       req,
  input  logic                                 cfg_write,
  input  logic [lpht_pkg::DIV_BITS-1:0]        cfg_data,
  output lpht_pkg::status_t                    status,
  output lpht_pkg::rsp_t                       result
);
  import lpht_pkg::*;

  logic [DIV_BITS-1:0]   divisor;
  logic [NUM_SLOTS-1:0]  slot_used;
  logic [KEY_BITS-1:0]   slot_keys [NUM_SLOTS];
  logic [KEY_BITS-1:0]   slot_key;
  logic                  req_type;
  logic [KEY_BITS-1:0]   key;
  logic [KEY_BITS-1:0]   key_sh;
  logic [DIV_BITS-1:0]   rem;
  logic [DIV_BITS-1:0]   rem_next;
  logic [STEP_BITS-1:0]  step;
  logic [SLOT_BITS-1:0]  ptr;
  logic [SLOT_BITS-1:0]  ptr_next;
  logic [COUNT_BITS-1:0] count;
  logic [SLOT_BITS-1:0]  home;

  always_comb begin
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS-1:0] r;
    r = rem;
    trial = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      trial = {r, key_sh[KEY_BITS-DIGIT_W+i]};
      if (trial >= {1'b0, divisor}) begin
        r = DIV_BITS'(trial - {1'b0, divisor});
      end else begin
        r = trial[DIV_BITS-1:0];
      end
    end
    rem_next = r;
  end

  assign home = (divisor == '0) ? '0 : rem[SLOT_BITS-1:0];

  always_comb begin
    ptr_next = ptr;
    if (cmd.probe_init) begin
      ptr_next = home;
    end else if (cmd.probe_next) begin
      ptr_next = ptr + 1'b1;
    end
  end

  assign status.div_last = (step == STEP_BITS'(DIV_STEPS - 1));
  assign status.is_search = req_type;
  assign status.used = slot_used[ptr];
  assign status.match = (slot_key == key);
  assign status.last = (count == COUNT_BITS'(NUM_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIVISOR_RESET;
      slot_used <= '0;
    end else begin
      if (cfg_write) begin
        divisor <= cfg_data;
      end
      if (cmd.write) begin
        slot_used[ptr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      slot_keys[ptr] <= key;
    end
    slot_key <= slot_keys[ptr_next];
    ptr <= ptr_next;
    if (cmd.load) begin
      req_type <= req.req_type;
      key <= req.key;
      key_sh <= req.key;
      rem <= '0;
      step <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      key_sh <= key_sh << DIGIT_W;
      step <= step + 1'b1;
    end
    if (cmd.probe_init) begin
      count <= COUNT_BITS'(1);
    end
    if (cmd.probe_next) begin
      count <= count + 1'b1;
    end
    if (cmd.finish) begin
      unique case (cmd.fin_kind)
        FIN_INSERT: result <= '{hit: 1'b0, probe_count: count, slot_index: ptr,
                                table_full: 1'b0};
        FIN_FULL: result <= '{hit: 1'b0, probe_count: COUNT_BITS'(NUM_SLOTS),
                              slot_index: '0, table_full: 1'b1};
        FIN_HIT: result <= '{hit: 1'b1, probe_count: count, slot_index: ptr,
                             table_full: 1'b0};
        FIN_MISS_EMPTY: result <= '{hit: 1'b0, probe_count: count, slot_index: '0,
                                    table_full: 1'b0};
        default: result <= '{hit: 1'b0, probe_count: COUNT_BITS'(NUM_SLOTS + 1),
                             slot_index: '0, table_full: 1'b0};
      endcase
    end
  end

endmodule

>>> src/lpht_ctrl.sv
module lpht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lpht_pkg::status_t status,
  output lpht_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import lpht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_HOME = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        cmd.probe_init = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (!status.is_search) begin
          if (!status.used) begin
            cmd.write = 1'b1;
            cmd.finish = 1'b1;
            cmd.fin_kind = FIN_INSERT;
          end else if (status.last) begin
            cmd.finish = 1'b1;
            cmd.fin_kind = FIN_FULL;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end else begin
          if (!status.used) begin
            cmd.finish = 1'b1;
            cmd.fin_kind = FIN_MISS_EMPTY;
          end else if (status.match) begin
            cmd.finish = 1'b1;
            cmd.fin_kind = FIN_HIT;
          end else if (status.last) begin
            cmd.finish = 1'b1;
            cmd.fin_kind = FIN_MISS_SCAN;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end
        if (cmd.finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

>>> src/lpht_checker.sv
module lpht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          cfg_ready,
  input logic                          done,
  input lpht_pkg::rsp_t                result
);
  import lpht_pkg::*;

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted request did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && cfg_ready && $past(busy))
    else $error("result strobe outside the end of a request");

  a_full_shape: assert property (@(posedge clk) disable iff (rst)
    done && result.table_full |->
      !result.hit && result.probe_count == COUNT_BITS'(NUM_SLOTS) &&
      result.slot_index == '0)
    else $error("refused insert has a malformed result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.probe_count != '0 &&
      result.probe_count <= COUNT_BITS'(NUM_SLOTS + 1) &&
      !(result.hit && result.probe_count == COUNT_BITS'(NUM_SLOTS + 1)))
    else $error("probe count out of range");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);
